FILE: rtl/core/rpa_pkg.sv
// shared types and constants for the axis rotation pipeline
`default_nettype none

package rpa_pkg;

    localparam int COORD_W = 16;
    localparam int AXIS_W  = 2;
    localparam int ANGLE_W = 16;

    // gain compensation 1/K, unsigned Q0.32
    localparam logic [31:0] GAIN_COMP = 32'h9B74_EDA8;

    typedef enum logic [AXIS_W-1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    // atan(2^-i) scaled so that a full circle is 2^32
    localparam logic [31:0] ATAN_TABLE [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        t_axis                      axis;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
    } t_meta;

endpackage

`default_nettype wire

FILE: rtl/core/rpa_in_if.sv
// input channel: point, angle and axis code
`default_nettype none

interface rpa_in_if import rpa_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [AXIS_W-1:0]          axis_code;
    logic signed [COORD_W-1:0]  in_x;
    logic signed [COORD_W-1:0]  in_y;
    logic signed [COORD_W-1:0]  in_z;
    logic signed [ANGLE_W-1:0]  turn_angle;

    modport source (
        output valid, axis_code, in_x, in_y, in_z, turn_angle,
        input  ready
    );
    modport sink (
        input  valid, axis_code, in_x, in_y, in_z, turn_angle,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/rpa_out_if.sv
// output channel: rotated point
`default_nettype none

interface rpa_out_if import rpa_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  out_x;
    logic signed [COORD_W-1:0]  out_y;
    logic signed [COORD_W-1:0]  out_z;

    modport source (
        output valid, out_x, out_y, out_z,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/rotate_point_about_axis_top.sv
// Rotates a Q4.12 point about one axis with a fully unrolled CORDIC pipeline; axis code 3
// passes the point through unchanged. One point enters per cycle while the output side keeps
// ready high. There is one register for the quadrant fold, one for the gain multiply, one
// per CORDIC iteration (N of them, CORDIC_STAGES capped at 32) and one for rounding and
// saturation. A stall on the output freezes the whole pipeline in place,
// so a held transfer on the output holds ready low on the input as well; ready also
// stays low while reset is held.
`default_nettype none

module rotate_point_about_axis_top import rpa_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    rpa_in_if.sink     i_pt,
    rpa_out_if.source  o_pt
);

    localparam int N    = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int PW   = COORD_W + 1;   // folded pair, may hold +32768
    localparam int W    = 52;            // prescaled pair with growth margin
    localparam int ZW   = 34;            // angle accumulator, circle = 2^32
    localparam int MW   = PW + 33;       // product width
    localparam int RW   = W + 1 - 32;    // rounded value before saturation
    localparam logic signed [ZW-1:0] Z_TOL = ZW'(64'(ATAN_TABLE[N-1]) * 2 + 64);

    // pipeline advance
    logic ce;
    assign ce         = !o_pt.valid || o_pt.ready;
    assign i_pt.ready = ce && i_rst_n;

    // valid bits: 0 fold, 1 multiply, k+2 iteration k, N+2 output
    logic [N+2:0] r_vld;

    // fold stage
    logic signed [PW-1:0]  r0_a, r0_b, n0_a, n0_b;
    logic signed [PW-1:0]  r0_ang, n0_ang;
    t_meta                 n0_meta;

    always_comb begin
        logic signed [PW-1:0] ang;
        logic signed [PW-1:0] pa;
        logic signed [PW-1:0] pb;
        n0_meta.axis = t_axis'(i_pt.axis_code);
        n0_meta.x    = i_pt.in_x;
        n0_meta.y    = i_pt.in_y;
        n0_meta.z    = i_pt.in_z;
        ang = PW'(i_pt.turn_angle);
        case (n0_meta.axis)
            AXIS_X: begin
                pa = PW'(i_pt.in_y);
                pb = PW'(i_pt.in_z);
            end
            AXIS_Y: begin
                pa = PW'(i_pt.in_z);
                pb = PW'(i_pt.in_x);
            end
            default: begin
                pa = PW'(i_pt.in_x);
                pb = PW'(i_pt.in_y);
            end
        endcase
        // fold into the half plane the iterations can reach
        if (ang > PW'(16384)) begin
            n0_a   = -pa;
            n0_b   = -pb;
            n0_ang = ang - PW'(32768);
        end else if (ang < -PW'(16384)) begin
            n0_a   = -pa;
            n0_b   = -pb;
            n0_ang = ang + PW'(32768);
        end else begin
            n0_a   = pa;
            n0_b   = pb;
            n0_ang = ang;
        end
    end

    t_meta r_meta [N+3];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r0_a      <= n0_a;
            r0_b      <= n0_b;
            r0_ang    <= n0_ang;
            r_meta[0] <= n0_meta;
        end
    end

    // gain multiply stage
    logic signed [W-1:0]  r_a [N+1];
    logic signed [W-1:0]  r_b [N+1];
    logic signed [ZW-1:0] r_z [N+1];
    logic signed [MW-1:0] prod_a, prod_b;
    logic signed [32:0]   gain_s;

    assign gain_s = $signed({1'b0, GAIN_COMP});
    assign prod_a = MW'(r0_a) * MW'(gain_s);
    assign prod_b = MW'(r0_b) * MW'(gain_s);

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_a[0]    <= W'(prod_a);
            r_b[0]    <= W'(prod_b);
            r_z[0]    <= ZW'(r0_ang) <<< 16;
            r_meta[1] <= r_meta[0];
        end
    end

    // one register stage per CORDIC iteration
    for (genvar k = 0; k < N; k++) begin : g_iter
        logic signed [W-1:0]  da, db;
        logic signed [ZW-1:0] step;
        assign da   = r_b[k] >>> k;
        assign db   = r_a[k] >>> k;
        assign step = $signed({2'b00, ATAN_TABLE[k]});

        always_ff @(posedge i_clk) begin
            if (ce) begin
                if (!r_z[k][ZW-1]) begin
                    r_a[k+1] <= r_a[k] - da;
                    r_b[k+1] <= r_b[k] + db;
                    r_z[k+1] <= r_z[k] - step;
                end else begin
                    r_a[k+1] <= r_a[k] + da;
                    r_b[k+1] <= r_b[k] - db;
                    r_z[k+1] <= r_z[k] + step;
                end
                r_meta[k+2] <= r_meta[k+1];
            end
        end
    end

    // round half up, drop 32 fraction bits, saturate
    function automatic logic signed [COORD_W-1:0] finish(input logic signed [W-1:0] v);
        logic signed [W:0]    s;
        logic signed [RW-1:0] r;
        s = (W+1)'(v) + (W+1)'(64'h8000_0000);
        r = s[W:32];
        if (r > RW'(32767)) begin
            finish = 16'sh7FFF;
        end else if (r < -RW'(32768)) begin
            finish = 16'sh8000;
        end else begin
            finish = r[COORD_W-1:0];
        end
    endfunction

    logic signed [COORD_W-1:0] ra, rb;
    logic signed [COORD_W-1:0] n_ox, n_oy, n_oz;
    logic signed [COORD_W-1:0] r_ox, r_oy, r_oz;
    t_meta                     m_last;

    assign ra     = finish(r_a[N]);
    assign rb     = finish(r_b[N]);
    assign m_last = r_meta[N+1];

    always_comb begin
        n_ox = m_last.x;
        n_oy = m_last.y;
        n_oz = m_last.z;
        case (m_last.axis)
            AXIS_X: begin
                n_oy = ra;
                n_oz = rb;
            end
            AXIS_Y: begin
                n_oz = ra;
                n_ox = rb;
            end
            AXIS_Z: begin
                n_ox = ra;
                n_oy = rb;
            end
            default: begin
                n_ox = m_last.x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_ox        <= n_ox;
            r_oy        <= n_oy;
            r_oz        <= n_oz;
            r_meta[N+2] <= m_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[N+1:0], i_pt.valid};
        end
    end

    assign o_pt.valid = r_vld[N+2];
    assign o_pt.out_x = r_ox;
    assign o_pt.out_y = r_oy;
    assign o_pt.out_z = r_oz;

`ifndef SYNTHESIS
    // a transfer on the input lands in the fold stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pt.valid && i_pt.ready |=> r_vld[0])
        else $error("accepted point did not enter the pipeline");

    // a stall holds every valid bit in place
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !ce |=> r_vld == $past(r_vld))
        else $error("pipeline moved during a stall");

    // the angle accumulator converges after the last iteration
    a_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[N+1] |-> (r_z[N] <= Z_TOL) && (r_z[N] >= -Z_TOL))
        else $error("residual angle out of range after the last iteration");

    // the unused stage entry keeps its meta
    a_meta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ce && r_vld[N+1] |=> r_meta[N+2] == $past(m_last))
        else $error("point meta lost at the output stage");
`endif

endmodule

`default_nettype wire
